// ===== sv/sgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared widths, grid limits, result codes and the controller/datapath
// command and status bundles for the segment grid crossing block.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int INT_BITS   = 5;
    localparam int GRID_CELLS = 31;
    localparam int COORD_W    = INT_BITS + FRAC_BITS;
    localparam int CNT_W      = INT_BITS;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int DIV_CNT_W  = $clog2(COORD_W + 1);

    localparam logic [CNT_W-1:0]   GRID_TOP = CNT_W'(GRID_CELLS - 1);
    localparam logic [COORD_W:0]   ONE_M1   = (COORD_W + 1)'((1 << FRAC_BITS) - 1);

    // point_kind codes
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_XCROSS = 2'd1;
    localparam logic [1:0] KIND_YCROSS = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_VERTICAL   = 2'd1;
    localparam logic [1:0] ST_HORIZONTAL = 2'd2;

    typedef logic [COORD_W-1:0] t_coord;

    // controller -> datapath
    typedef struct packed {
        logic latch_seg;   // capture a new segment
        logic head_emit;   // load start point or error result
        logic axis_load;   // select pass axis, load counter with first line
        logic axis_y;      // axis for axis_load: 0 x pass, 1 y pass
        logic mul0;        // first partial product
        logic mul1;        // second partial product
        logic div_start;   // launch the divider
        logic cross_emit;  // load a crossing point
        logic cnt_inc;     // step to the next grid line
        logic end_emit;    // load the end point
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic vertical;
        logic horiz_err;
        logic x_any;
        logic y_any;
        logic axis_y;
        logic cnt_at_hi;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/sgc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit COORD_W bits (numerator < den << COORD_W).
// ----------------------------------------------------------------------------
module sgc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sgc_pkg::PROD_W-1:0]  i_num,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_den,
    output logic                             o_done,
    output logic [sgc_pkg::COORD_W-1:0]      o_quot
);
    import sgc_pkg::*;

    logic [COORD_W-1:0]   r_rem, n_rem;
    logic [COORD_W-1:0]   r_q, n_q;
    logic [COORD_W-1:0]   r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [COORD_W:0]     w_trial;
    logic                 w_fits;

    assign w_trial = {r_rem, r_q[COORD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_comb begin
        if (w_fits) begin
            n_rem = COORD_W'(w_trial - {1'b0, r_den});
        end else begin
            n_rem = w_trial[COORD_W-1:0];
        end
        n_q = {r_q[COORD_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= DIV_CNT_W'(COORD_W);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != DIV_CNT_W'(1));
                r_done <= (r_cnt == DIV_CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1:COORD_W];
            r_q   <= i_num[COORD_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== sv/sgc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_datapath
// Segment registers, grid range decode, interpolation multiplier and
// divider, grid line counter and the output register.
// ----------------------------------------------------------------------------
module sgc_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sgc_pkg::t_dp_cmd            i_cmd,
    output sgc_pkg::t_dp_stat                o_stat,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_end_y,
    input  wire logic                        i_out_stall,
    output logic                             o_out_valid,
    output logic [sgc_pkg::COORD_W-1:0]      o_point_x,
    output logic [sgc_pkg::COORD_W-1:0]      o_point_y,
    output logic [1:0]                       o_point_kind,
    output logic [1:0]                       o_status,
    output logic                             o_last_point
);
    import sgc_pkg::*;

    t_coord r_x1, r_y1, r_x2, r_y2;
    logic [CNT_W-1:0] r_cnt;
    logic             r_axis_y;
    logic [PROD_W-1:0] r_p0, r_p1;

    logic             r_out_valid;
    t_coord           r_px, r_py;
    logic [1:0]       r_kind, r_status;
    logic             r_last;

    logic [COORD_W:0]  w_xsum, w_ysum;
    logic [CNT_W:0]    w_xlo, w_ylo;
    logic [CNT_W-1:0]  w_xhi, w_yhi, w_hi;
    logic              w_vertical, w_horiz_err, w_x_any, w_y_any;
    t_coord            w_t, w_t0, w_t1, w_v0, w_v1, w_den;
    logic              w_div_done;
    t_coord            w_quot;
    logic [PROD_W-1:0] w_num;
    logic              w_out_free;

    // grid line range of each axis: ceil(start) .. min(floor(end), top line)
    assign w_xsum = {1'b0, r_x1} + ONE_M1;
    assign w_ysum = {1'b0, r_y1} + ONE_M1;
    assign w_xlo  = w_xsum[COORD_W:FRAC_BITS];
    assign w_ylo  = w_ysum[COORD_W:FRAC_BITS];
    assign w_xhi  = (r_x2[COORD_W-1:FRAC_BITS] > GRID_TOP) ? GRID_TOP
                                                         : r_x2[COORD_W-1:FRAC_BITS];
    assign w_yhi  = (r_y2[COORD_W-1:FRAC_BITS] > GRID_TOP) ? GRID_TOP
                                                         : r_y2[COORD_W-1:FRAC_BITS];
    assign w_x_any     = (w_xlo <= {1'b0, w_xhi});
    assign w_y_any     = (w_ylo <= {1'b0, w_yhi});
    assign w_vertical  = (r_x1 == r_x2);
    assign w_horiz_err = (r_y1 == r_y2) && w_y_any;
    assign w_hi        = r_axis_y ? w_yhi : w_xhi;

    // interpolation operands: value = (v0*(t1-t) + v1*(t-t0)) / (t1-t0)
    assign w_t  = {r_cnt, {FRAC_BITS{1'b0}}};
    assign w_t0 = r_axis_y ? r_y1 : r_x1;
    assign w_t1 = r_axis_y ? r_y2 : r_x2;
    assign w_v0 = r_axis_y ? r_x1 : r_y1;
    assign w_v1 = r_axis_y ? r_x2 : r_y2;
    assign w_den = w_t1 - w_t0;
    assign w_num = r_p0 + r_p1;

    sgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul0) begin
            r_p0 <= PROD_W'(w_v0) * PROD_W'(w_t1 - w_t);
        end
        if (i_cmd.mul1) begin
            r_p1 <= PROD_W'(w_v1) * PROD_W'(w_t - w_t0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1     <= '0;
            r_y1     <= '0;
            r_x2     <= '0;
            r_y2     <= '0;
            r_cnt    <= '0;
            r_axis_y <= 1'b0;
        end else begin
            if (i_cmd.latch_seg) begin
                r_x1 <= i_start_x;
                r_y1 <= i_start_y;
                r_x2 <= i_end_x;
                r_y2 <= i_end_y;
            end
            if (i_cmd.axis_load) begin
                r_axis_y <= i_cmd.axis_y;
                r_cnt    <= i_cmd.axis_y ? w_ylo[CNT_W-1:0] : w_xlo[CNT_W-1:0];
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.end_emit) begin
                r_cnt <= '0;
            end
        end
    end

    // output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.head_emit || i_cmd.cross_emit || i_cmd.end_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_emit) begin
            r_kind <= KIND_START;
            if (w_vertical || w_horiz_err) begin
                r_px     <= '0;
                r_py     <= '0;
                r_status <= w_vertical ? ST_VERTICAL : ST_HORIZONTAL;
                r_last   <= 1'b1;
            end else begin
                r_px     <= r_x1;
                r_py     <= r_y1;
                r_status <= ST_OK;
                r_last   <= 1'b0;
            end
        end else if (i_cmd.cross_emit) begin
            r_status <= ST_OK;
            r_last   <= 1'b0;
            if (r_axis_y) begin
                r_px   <= w_quot;
                r_py   <= w_t;
                r_kind <= KIND_YCROSS;
            end else begin
                r_px   <= w_t;
                r_py   <= w_quot;
                r_kind <= KIND_XCROSS;
            end
        end else if (i_cmd.end_emit) begin
            r_px     <= r_x2;
            r_py     <= r_y2;
            r_kind   <= KIND_END;
            r_status <= ST_OK;
            r_last   <= 1'b1;
        end
    end

    always_comb begin
        o_stat.vertical  = w_vertical;
        o_stat.horiz_err = w_horiz_err;
        o_stat.x_any     = w_x_any;
        o_stat.y_any     = w_y_any;
        o_stat.axis_y    = r_axis_y;
        o_stat.cnt_at_hi = (r_cnt == w_hi);
        o_stat.div_done  = w_div_done;
        o_stat.out_free  = w_out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_point_x    = r_px;
    assign o_point_y    = r_py;
    assign o_point_kind = r_kind;
    assign o_status     = r_status;
    assign o_last_point = r_last;

endmodule
`default_nettype wire

// ===== sv/sgc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_ctrl
// Run sequencer: head result, x pass, y pass, end point. Each crossing
// goes through two multiply steps and one divide.
// ----------------------------------------------------------------------------
module sgc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sgc_pkg::t_dp_stat i_stat,
    output sgc_pkg::t_dp_cmd       o_cmd
);
    import sgc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HEAD  = 8'b0000_0010,
        S_MUL0  = 8'b0000_0100,
        S_MUL1  = 8'b0000_1000,
        S_DIVS  = 8'b0001_0000,
        S_DIVW  = 8'b0010_0000,
        S_CROSS = 8'b0100_0000,
        S_END   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_seg = 1'b1;
                    n_state         = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_stat.out_free) begin
                    o_cmd.head_emit = 1'b1;
                    if (i_stat.vertical || i_stat.horiz_err) begin
                        n_state = S_IDLE;
                    end else if (i_stat.x_any) begin
                        o_cmd.axis_load = 1'b1;
                        o_cmd.axis_y    = 1'b0;
                        n_state         = S_MUL0;
                    end else if (i_stat.y_any) begin
                        o_cmd.axis_load = 1'b1;
                        o_cmd.axis_y    = 1'b1;
                        n_state         = S_MUL0;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                if (i_stat.out_free) begin
                    o_cmd.cross_emit = 1'b1;
                    if (!i_stat.cnt_at_hi) begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_MUL0;
                    end else if (!i_stat.axis_y && i_stat.y_any) begin
                        o_cmd.axis_load = 1'b1;
                        o_cmd.axis_y    = 1'b1;
                        n_state         = S_MUL0;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.end_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== sv/segment_grid_crossings.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_grid_crossings
// Emits the start point, the integer grid line crossings and the end point
// of one line segment given in unsigned Q5.8, or one error result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_start_x, i_start_y, i_end_x,
//   i_end_y. A transaction completes when i_valid is high and o_stall low.
//   Output channel: o_valid / i_stall with o_point_x, o_point_y,
//   o_point_kind, o_status, o_last_point. o_last_point flags the final
//   transaction of a segment's run.
//   One segment is in flight at a time: o_stall is high from the cycle after
//   acceptance until the end point (or the single error result) has been
//   loaded into the output register. A new segment can be taken while that
//   last result still waits downstream.
//   The start point is loaded once the output register is free. Each
//   crossing then runs the multiply states MUL0 and MUL1, the divider load,
//   a divide of COORD_W quotient bits, the wait for divider done and the
//   emit state. The end point follows the last crossing. A run's length
//   is set mostly by the one-bit-per-cycle divider.
//   Output stall simply holds the sequencer at its next emit step.
//   Reset (i_rst_n low, synchronous) empties the output register and returns
//   the sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module segment_grid_crossings (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [sgc_pkg::COORD_W-1:0] i_end_y,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [sgc_pkg::COORD_W-1:0]      o_point_x,
    output logic [sgc_pkg::COORD_W-1:0]      o_point_y,
    output logic [1:0]                       o_point_kind,
    output logic [1:0]                       o_status,
    output logic                             o_last_point
);
    import sgc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: walks head, x pass, y pass, end
    sgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: segment regs, range decode, interpolation, output register
    sgc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_point_kind (o_point_kind),
        .o_status     (o_status),
        .o_last_point (o_last_point)
    );

`ifndef NO_ASSERTIONS
    // error results are lone start-kind results that close the run
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_last_point && (o_point_kind == KIND_START))
        else $error("error result not marked last");

    // a normal run closes only on its end point
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_point && (o_status == ST_OK) |-> (o_point_kind == KIND_END))
        else $error("last flag on non-end point");

    // x crossings sit exactly on an integer x line
    a_xcross_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_point_kind == KIND_XCROSS) |-> (o_point_x[FRAC_BITS-1:0] == '0))
        else $error("x crossing off grid");

    // y crossings sit exactly on an integer y line
    a_ycross_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_point_kind == KIND_YCROSS) |-> (o_point_y[FRAC_BITS-1:0] == '0))
        else $error("y crossing off grid");
`endif

endmodule
`default_nettype wire
